@@ hdl/box_circle_collision_correction_macros.svh @@
// ----------------------------------------------------------------------------
// Box/circle collision correction assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOX_CIRCLE_COLLISION_CORRECTION_MACROS_SVH
`define BOX_CIRCLE_COLLISION_CORRECTION_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define BCCC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bccc assertion failed");
// next-cycle implication, always on
`define BCCC_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bccc assertion failed");
`else
`define BCCC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BCCC_ASSERT_NXT(label, clk, ante, cons)
`endif
`endif

@@ hdl/bccc_pkg.sv @@
// ----------------------------------------------------------------------------
// Box/circle collision correction package
// Widths, pipeline depths and stage types shared by the block.
// ----------------------------------------------------------------------------
package bccc_pkg;

    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 31;
    localparam int EDGE_W     = 35;
    localparam int DIFF_W     = 36;
    localparam int RAD_W      = 32;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 64;
    localparam int NUM_W      = 65;
    localparam int QUO_W      = 33;
    localparam int OUT_W      = 32;
    localparam int SQ_STAGES  = 32;
    localparam int SQ_REM_W   = 34;
    localparam int DIV_STAGES = 33;

    localparam logic [SIZE_W-1:0] TOL_RESET = 31'd6554;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_BOX_BOX,
        MODE_CIRC_CIRC,
        MODE_MIXED
    } mode_t;

    // doubled centers and box edges of both shapes
    typedef struct packed {
        logic                     mc;
        logic                     rc;
        logic signed [EDGE_W-1:0] mcx, mcy, rcx, rcy;
        logic signed [EDGE_W-1:0] mx1, mx2, my1, my2;
        logic signed [EDGE_W-1:0] rx1, rx2, ry1, ry2;
        logic [SIZE_W-1:0]        msx, rsx;
    } geo_t;

    // circle/box roles, box-box overlap
    typedef struct packed {
        mode_t                    mode;
        logic                     neg;
        logic signed [DIFF_W-1:0] bb_x, bb_y;
        logic signed [EDGE_W-1:0] cx, cy, x1, x2, y1, y2;
        logic [RAD_W-1:0]         rad;
    } role_t;

    // edge push and the one contact vector to scale
    typedef struct packed {
        logic signed [ACC_W-1:0]  base_x, base_y;
        logic signed [DIFF_W-1:0] vx, vy;
        logic [RAD_W-1:0]         rad;
        logic                     corner;
        logic [1:0]               shift;
        logic                     neg;
    } vec_t;

    // sideband carried through root and divider
    typedef struct packed {
        logic signed [ACC_W-1:0] base_x, base_y;
        logic [RAD_W-1:0]        ax, ay, rad, len, rml;
        logic                    sgn_x, sgn_y, hit, neg;
        logic [1:0]              shift;
    } side_t;

endpackage

@@ hdl/bccc_div.sv @@
// ----------------------------------------------------------------------------
// Box/circle collision correction divider
// Restoring divider, one quotient bit per stage, DIV_STAGES stages deep.
// ----------------------------------------------------------------------------
module bccc_div (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [bccc_pkg::NUM_W-1:0]   num,
    input  logic [bccc_pkg::RAD_W-1:0]   den,
    output logic [bccc_pkg::QUO_W-1:0]   quo
);
    import bccc_pkg::*;

    localparam int REST_W = NUM_W - RAD_W;

    logic [RAD_W-1:0]  rem_reg  [DIV_STAGES];
    logic [RAD_W-1:0]  rem_next [DIV_STAGES];
    logic [REST_W-1:0] rest_reg [DIV_STAGES];
    logic [REST_W-1:0] rest_next[DIV_STAGES];
    logic [QUO_W-1:0]  quo_reg  [DIV_STAGES];
    logic [QUO_W-1:0]  quo_next [DIV_STAGES];
    logic [RAD_W-1:0]  den_reg  [DIV_STAGES];
    logic [RAD_W-1:0]  den_next [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
        logic [RAD_W-1:0]  rem_in;
        logic [REST_W-1:0] rest_in;
        logic [QUO_W-1:0]  quo_in;
        logic [RAD_W-1:0]  den_in;
        logic [RAD_W:0]    trial;
        logic              take;
        if (j == 0) begin : g_head
            assign rem_in  = num[NUM_W-1 -: RAD_W];
            assign rest_in = num[REST_W-1:0];
            assign quo_in  = '0;
            assign den_in  = den;
        end else begin : g_body
            assign rem_in  = rem_reg[j-1];
            assign rest_in = rest_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign den_in  = den_reg[j-1];
        end
        assign trial        = {rem_in, rest_in[REST_W-1]};
        assign take         = trial >= {1'b0, den_in};
        assign rem_next[j]  = take ? RAD_W'(trial - {1'b0, den_in}) : trial[RAD_W-1:0];
        assign rest_next[j] = {rest_in[REST_W-2:0], 1'b0};
        assign quo_next[j]  = {quo_in[QUO_W-2:0], take};
        assign den_next[j]  = den_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                rem_reg[j]  <= rem_next[j];
                rest_reg[j] <= rest_next[j];
                quo_reg[j]  <= quo_next[j];
                den_reg[j]  <= den_next[j];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

@@ hdl/box_circle_collision_correction.sv @@
// ----------------------------------------------------------------------------
// Box/circle collision correction
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits. The square root has 32 stages and each divider 33.
// Reset (aresetn low, synchronous) empties the pipeline and sets the
// tolerance register tol_reg to 6554.
// ----------------------------------------------------------------------------
`include "box_circle_collision_correction_macros.svh"

module box_circle_collision_correction (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bccc_pkg::SIZE_W-1:0]          cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_first_is_circle,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_first_center_x,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_first_center_y,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_first_size_x,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_first_size_y,
    input  logic                                 s_second_is_circle,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_second_center_x,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_second_center_y,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_second_size_x,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_second_size_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [bccc_pkg::OUT_W-1:0]    m_push_x,
    output logic signed [bccc_pkg::OUT_W-1:0]    m_push_y
);
    import bccc_pkg::*;

    logic en;
    logic [SIZE_W-1:0] tol_reg;

    geo_t  s1_reg, s1_next;
    role_t s2_reg, s2_next;
    vec_t  s3_reg, s3_next;
    side_t s4_reg, s4_next;
    side_t s5_reg;
    side_t s6_reg, s6_next;
    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    logic [PROD_W-1:0] sx_reg, sy_reg, rr_reg;
    logic [PROD_W-1:0] q_reg, q_next;

    logic [SQ_REM_W-1:0] sq_rem_reg  [SQ_STAGES];
    logic [SQ_REM_W-1:0] sq_rem_next [SQ_STAGES];
    logic [RAD_W-1:0]    sq_root_reg [SQ_STAGES];
    logic [RAD_W-1:0]    sq_root_next[SQ_STAGES];
    logic [PROD_W-1:0]   sq_q_reg    [SQ_STAGES];
    logic [PROD_W-1:0]   sq_q_next   [SQ_STAGES];
    side_t               sq_side_reg [SQ_STAGES];
    side_t               sq_side_next[SQ_STAGES];
    logic                sq_vld_reg  [SQ_STAGES];
    logic                sq_vld_next [SQ_STAGES];

    side_t sl_reg, sl_next;
    side_t sm_reg;
    side_t sn_reg;
    logic  vl_reg, vm_reg, vn_reg;
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [NUM_W-1:0]  num_x_reg, num_y_reg;

    logic [QUO_W-1:0] quo_x, quo_y;
    side_t dv_side_reg [DIV_STAGES];
    logic  dv_vld_reg  [DIV_STAGES];

    logic signed [ACC_W-1:0] tot_x_reg, tot_y_reg, tot_x_next, tot_y_next;
    logic neg_reg, vf_reg;

    logic signed [OUT_W-1:0] push_x_reg, push_y_reg, push_x_next, push_y_next;
    logic m_valid_reg;

    // the whole pipe advances unless the output word is stalled
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // stage 1: doubled centers and box edges
    always_comb begin
        logic signed [EDGE_W-1:0] mcx, mcy, rcx, rcy, msx, msy, rsx, rsy;
        mcx = EDGE_W'(s_first_center_x) <<< 1;
        mcy = EDGE_W'(s_first_center_y) <<< 1;
        rcx = EDGE_W'(s_second_center_x) <<< 1;
        rcy = EDGE_W'(s_second_center_y) <<< 1;
        msx = signed'(EDGE_W'(s_first_size_x));
        msy = signed'(EDGE_W'(s_first_size_y));
        rsx = signed'(EDGE_W'(s_second_size_x));
        rsy = signed'(EDGE_W'(s_second_size_y));
        s1_next.mc  = s_first_is_circle;
        s1_next.rc  = s_second_is_circle;
        s1_next.mcx = mcx;
        s1_next.mcy = mcy;
        s1_next.rcx = rcx;
        s1_next.rcy = rcy;
        s1_next.mx1 = mcx - msx;
        s1_next.mx2 = mcx + msx;
        s1_next.my1 = mcy - msy;
        s1_next.my2 = mcy + msy;
        s1_next.rx1 = rcx - rsx;
        s1_next.rx2 = rcx + rsx;
        s1_next.ry1 = rcy - rsy;
        s1_next.ry2 = rcy + rsy;
        s1_next.msx = s_first_size_x;
        s1_next.rsx = s_second_size_x;
    end

    // stage 2: box-box overlap, pick circle and box roles
    always_comb begin
        logic xov, yov;
        xov = !((s1_reg.rx1 > s1_reg.mx2) || (s1_reg.rx2 < s1_reg.mx1));
        yov = !((s1_reg.ry1 > s1_reg.my2) || (s1_reg.ry2 < s1_reg.my1));
        s2_next.bb_x = '0;
        if (yov && s1_reg.rcx > s1_reg.mcx && s1_reg.rx1 < s1_reg.mx2) begin
            s2_next.bb_x = DIFF_W'(s1_reg.rx1) - DIFF_W'(s1_reg.mx2);
        end else if (yov && s1_reg.rcx < s1_reg.mcx && s1_reg.rx2 > s1_reg.mx1) begin
            s2_next.bb_x = DIFF_W'(s1_reg.rx2) - DIFF_W'(s1_reg.mx1);
        end
        s2_next.bb_y = '0;
        if (xov && s1_reg.rcy > s1_reg.mcy && s1_reg.ry1 < s1_reg.my2) begin
            s2_next.bb_y = DIFF_W'(s1_reg.ry1) - DIFF_W'(s1_reg.my2);
        end else if (xov && s1_reg.rcy < s1_reg.mcy && s1_reg.ry2 > s1_reg.my1) begin
            s2_next.bb_y = DIFF_W'(s1_reg.ry2) - DIFF_W'(s1_reg.my1);
        end
        s2_next.neg = !s1_reg.mc && s1_reg.rc;
        if (s1_reg.mc && s1_reg.rc) begin
            // contact point is the second center, radius the sum
            s2_next.mode = MODE_CIRC_CIRC;
            s2_next.cx   = s1_reg.mcx;
            s2_next.cy   = s1_reg.mcy;
            s2_next.x1   = s1_reg.rcx;
            s2_next.x2   = s1_reg.rcx;
            s2_next.y1   = s1_reg.rcy;
            s2_next.y2   = s1_reg.rcy;
            s2_next.rad  = RAD_W'(s1_reg.msx) + RAD_W'(s1_reg.rsx);
        end else if (s1_reg.mc) begin
            s2_next.mode = MODE_MIXED;
            s2_next.cx   = s1_reg.mcx;
            s2_next.cy   = s1_reg.mcy;
            s2_next.x1   = s1_reg.rx1;
            s2_next.x2   = s1_reg.rx2;
            s2_next.y1   = s1_reg.ry1;
            s2_next.y2   = s1_reg.ry2;
            s2_next.rad  = RAD_W'(s1_reg.msx);
        end else if (s1_reg.rc) begin
            s2_next.mode = MODE_MIXED;
            s2_next.cx   = s1_reg.rcx;
            s2_next.cy   = s1_reg.rcy;
            s2_next.x1   = s1_reg.mx1;
            s2_next.x2   = s1_reg.mx2;
            s2_next.y1   = s1_reg.my1;
            s2_next.y2   = s1_reg.my2;
            s2_next.rad  = RAD_W'(s1_reg.rsx);
        end else begin
            s2_next.mode = MODE_BOX_BOX;
            s2_next.cx   = s1_reg.mcx;
            s2_next.cy   = s1_reg.mcy;
            s2_next.x1   = s1_reg.rx1;
            s2_next.x2   = s1_reg.rx2;
            s2_next.y1   = s1_reg.ry1;
            s2_next.y2   = s1_reg.ry2;
            s2_next.rad  = '0;
        end
    end

    // stage 3: tolerance, edge pushes, corner selection
    always_comb begin
        logic signed [DIFF_W-1:0] radw, dxl, dxr, dyl, dyr, ex, ey, kvx, kvy;
        logic [DIFF_W-1:0]        mag_x, mag_y, tol2;
        logic                     cxl, cxg, cyl, cyg, any;
        logic [1:0]               shift;
        logic signed [EDGE_W-1:0] kx, ky;
        radw  = signed'(DIFF_W'(s2_reg.rad));
        dxl   = DIFF_W'(s2_reg.x1) - DIFF_W'(s2_reg.cx);
        dxr   = DIFF_W'(s2_reg.cx) - DIFF_W'(s2_reg.x2);
        dyl   = DIFF_W'(s2_reg.y1) - DIFF_W'(s2_reg.cy);
        dyr   = DIFF_W'(s2_reg.cy) - DIFF_W'(s2_reg.y2);
        ex    = '0;
        ey    = '0;
        if (s2_reg.cy > s2_reg.y1 && s2_reg.cy < s2_reg.y2) begin
            if (s2_reg.cx < s2_reg.x1 && dxl < radw) begin
                ex = dxl - radw;
            end else if (s2_reg.cx > s2_reg.x2 && dxr < radw) begin
                ex = radw - dxr;
            end
        end
        if (s2_reg.cx > s2_reg.x1 && s2_reg.cx < s2_reg.x2) begin
            if (s2_reg.cy < s2_reg.y1 && dyl < radw) begin
                ey = dyl - radw;
            end else if (s2_reg.cy > s2_reg.y2 && dyr < radw) begin
                ey = radw - dyr;
            end
        end
        cxl = s2_reg.cx <= s2_reg.x1;
        cxg = s2_reg.cx >= s2_reg.x2;
        cyl = s2_reg.cy <= s2_reg.y1;
        cyg = s2_reg.cy >= s2_reg.y2;
        any = (cxl || cxg) && (cyl || cyg);
        // a flat box can hit several coincident corners: scale by their count
        if (cxl && cxg && cyl && cyg) begin
            shift = 2'd2;
        end else if ((cxl && cxg && (cyl || cyg)) || (cyl && cyg && (cxl || cxg))) begin
            shift = 2'd1;
        end else begin
            shift = 2'd0;
        end
        kx    = cxl ? s2_reg.x1 : s2_reg.x2;
        ky    = cyl ? s2_reg.y1 : s2_reg.y2;
        kvx   = DIFF_W'(kx) - DIFF_W'(s2_reg.cx);
        kvy   = DIFF_W'(ky) - DIFF_W'(s2_reg.cy);
        mag_x = s2_reg.bb_x < 0 ? DIFF_W'(-s2_reg.bb_x) : DIFF_W'(s2_reg.bb_x);
        mag_y = s2_reg.bb_y < 0 ? DIFF_W'(-s2_reg.bb_y) : DIFF_W'(s2_reg.bb_y);
        tol2  = DIFF_W'({tol_reg, 1'b0});
        s3_next.rad = s2_reg.rad;
        s3_next.neg = s2_reg.neg;
        case (s2_reg.mode)
            MODE_BOX_BOX: begin
                s3_next.base_x = (mag_x > tol2) ? '0 : ACC_W'(s2_reg.bb_x);
                s3_next.base_y = (mag_y > tol2) ? '0 : ACC_W'(s2_reg.bb_y);
                s3_next.vx     = '0;
                s3_next.vy     = '0;
                s3_next.corner = 1'b0;
                s3_next.shift  = 2'd0;
            end
            MODE_CIRC_CIRC: begin
                s3_next.base_x = '0;
                s3_next.base_y = '0;
                s3_next.vx     = dxl;
                s3_next.vy     = dyl;
                s3_next.corner = 1'b1;
                s3_next.shift  = 2'd0;
            end
            MODE_MIXED: begin
                s3_next.base_x = ACC_W'(ex);
                s3_next.base_y = ACC_W'(ey);
                s3_next.vx     = kvx;
                s3_next.vy     = kvy;
                s3_next.corner = any;
                s3_next.shift  = shift;
            end
            default: begin
                s3_next.base_x = '0;
                s3_next.base_y = '0;
                s3_next.vx     = '0;
                s3_next.vy     = '0;
                s3_next.corner = 1'b0;
                s3_next.shift  = 2'd0;
            end
        endcase
    end

    // stage 4: magnitudes and the per-axis radius test
    always_comb begin
        logic [DIFF_W-1:0] ax, ay;
        ax = s3_reg.vx < 0 ? DIFF_W'(-s3_reg.vx) : DIFF_W'(s3_reg.vx);
        ay = s3_reg.vy < 0 ? DIFF_W'(-s3_reg.vy) : DIFF_W'(s3_reg.vy);
        s4_next.base_x = s3_reg.base_x;
        s4_next.base_y = s3_reg.base_y;
        s4_next.ax     = ax[RAD_W-1:0];
        s4_next.ay     = ay[RAD_W-1:0];
        s4_next.rad    = s3_reg.rad;
        s4_next.len    = '0;
        s4_next.rml    = '0;
        s4_next.sgn_x  = s3_reg.vx > 0;
        s4_next.sgn_y  = s3_reg.vy > 0;
        s4_next.hit    = s3_reg.corner && (ax < DIFF_W'(s3_reg.rad))
                         && (ay < DIFF_W'(s3_reg.rad));
        s4_next.neg    = s3_reg.neg;
        s4_next.shift  = s3_reg.shift;
    end

    // stage 6: squared distance against squared radius
    always_comb begin
        logic [PROD_W:0] sum;
        sum     = {1'b0, sx_reg} + {1'b0, sy_reg};
        s6_next = s5_reg;
        s6_next.hit = s5_reg.hit && (sum < {1'b0, rr_reg});
        q_next  = sum[PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s4_reg;
            sx_reg <= PROD_W'(s4_reg.ax) * PROD_W'(s4_reg.ax);
            sy_reg <= PROD_W'(s4_reg.ay) * PROD_W'(s4_reg.ay);
            rr_reg <= PROD_W'(s4_reg.rad) * PROD_W'(s4_reg.rad);
            s6_reg <= s6_next;
            q_reg  <= q_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
        logic [SQ_REM_W-1:0] rem_in;
        logic [RAD_W-1:0]    root_in;
        logic [PROD_W-1:0]   q_in;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W+1:0] test;
        logic                take;
        if (j == 0) begin : g_head
            assign rem_in          = '0;
            assign root_in         = '0;
            assign q_in            = q_reg;
            assign sq_side_next[j] = s6_reg;
            assign sq_vld_next[j]  = v6_reg;
        end else begin : g_body
            assign rem_in          = sq_rem_reg[j-1];
            assign root_in         = sq_root_reg[j-1];
            assign q_in            = sq_q_reg[j-1];
            assign sq_side_next[j] = sq_side_reg[j-1];
            assign sq_vld_next[j]  = sq_vld_reg[j-1];
        end
        assign trial           = {rem_in, q_in[PROD_W-1 -: 2]};
        assign test            = (SQ_REM_W+2)'({root_in, 2'b01});
        assign take            = trial >= test;
        assign sq_rem_next[j]  = take ? SQ_REM_W'(trial - test) : SQ_REM_W'(trial);
        assign sq_root_next[j] = {root_in[RAD_W-2:0], take};
        assign sq_q_next[j]    = {q_in[PROD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < SQ_STAGES; j++) begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                sq_q_reg[j]    <= sq_q_next[j];
                sq_side_reg[j] <= sq_side_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SQ_STAGES; j++) begin
                sq_vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            for (int j = 0; j < SQ_STAGES; j++) begin
                sq_vld_reg[j] <= sq_vld_next[j];
            end
        end
    end

    always_comb begin
        sl_next     = sq_side_reg[SQ_STAGES-1];
        sl_next.len = sq_root_reg[SQ_STAGES-1];
        sl_next.rml = sq_side_reg[SQ_STAGES-1].rad - sq_root_reg[SQ_STAGES-1];
    end

    // scale numerators, then round to nearest before dividing
    always_ff @(posedge aclk) begin
        if (en) begin
            sl_reg     <= sl_next;
            sm_reg     <= sl_reg;
            prod_x_reg <= PROD_W'(sl_reg.ax) * PROD_W'(sl_reg.rml);
            prod_y_reg <= PROD_W'(sl_reg.ay) * PROD_W'(sl_reg.rml);
            sn_reg     <= sm_reg;
            num_x_reg  <= {1'b0, prod_x_reg} + NUM_W'(sm_reg.len >> 1);
            num_y_reg  <= {1'b0, prod_y_reg} + NUM_W'(sm_reg.len >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
            vm_reg <= 1'b0;
            vn_reg <= 1'b0;
        end else if (en) begin
            vl_reg <= sq_vld_reg[SQ_STAGES-1];
            vm_reg <= vl_reg;
            vn_reg <= vm_reg;
        end
    end

    bccc_div u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (num_x_reg),
        .den  (sn_reg.len),
        .quo  (quo_x)
    );

    bccc_div u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (num_y_reg),
        .den  (sn_reg.len),
        .quo  (quo_y)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= sn_reg;
            for (int j = 1; j < DIV_STAGES; j++) begin
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DIV_STAGES; j++) begin
                dv_vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            dv_vld_reg[0] <= vn_reg;
            for (int j = 1; j < DIV_STAGES; j++) begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end
    end

    // sign, corner count and edge push
    always_comb begin
        side_t                   sd;
        logic                    use_q;
        logic signed [ACC_W-1:0] mx, my, px, py;
        sd    = dv_side_reg[DIV_STAGES-1];
        use_q = sd.hit && (sd.len != '0);
        mx    = use_q ? signed'(ACC_W'(quo_x)) : '0;
        my    = use_q ? signed'(ACC_W'(quo_y)) : '0;
        px    = sd.sgn_x ? -mx : mx;
        py    = sd.sgn_y ? -my : my;
        tot_x_next = sd.base_x + (px <<< sd.shift);
        tot_y_next = sd.base_y + (py <<< sd.shift);
    end

    // negate when the box came first against a circle, halve away from zero, saturate
    always_comb begin
        logic signed [ACC_W-1:0] sv_x, sv_y, hv_x, hv_y;
        sv_x = neg_reg ? -tot_x_reg : tot_x_reg;
        sv_y = neg_reg ? -tot_y_reg : tot_y_reg;
        hv_x = sv_x < 0 ? (sv_x >>> 1) : ((sv_x + signed'(ACC_W'(1))) >>> 1);
        hv_y = sv_y < 0 ? (sv_y >>> 1) : ((sv_y + signed'(ACC_W'(1))) >>> 1);
        if (hv_x > SAT_HI) begin
            push_x_next = SAT_HI[OUT_W-1:0];
        end else if (hv_x < SAT_LO) begin
            push_x_next = SAT_LO[OUT_W-1:0];
        end else begin
            push_x_next = hv_x[OUT_W-1:0];
        end
        if (hv_y > SAT_HI) begin
            push_y_next = SAT_HI[OUT_W-1:0];
        end else if (hv_y < SAT_LO) begin
            push_y_next = SAT_LO[OUT_W-1:0];
        end else begin
            push_y_next = hv_y[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tot_x_reg  <= tot_x_next;
            tot_y_reg  <= tot_y_next;
            neg_reg    <= dv_side_reg[DIV_STAGES-1].neg;
            push_x_reg <= push_x_next;
            push_y_reg <= push_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vf_reg      <= dv_vld_reg[DIV_STAGES-1];
            m_valid_reg <= vf_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_push_x = push_x_reg;
    assign m_push_y = push_y_reg;

    `BCCC_ASSERT_NXT(a_reset_empties, aclk, !aresetn, !m_valid_reg)
    `BCCC_ASSERT_IMP(a_hit_in_radius, aclk, aresetn, v4_reg && s4_reg.hit, (s4_reg.ax < s4_reg.rad) && (s4_reg.ay < s4_reg.rad))
    `BCCC_ASSERT_IMP(a_root_below_rad, aclk, aresetn, sq_vld_reg[SQ_STAGES-1] && sq_side_reg[SQ_STAGES-1].hit, sq_root_reg[SQ_STAGES-1] < sq_side_reg[SQ_STAGES-1].rad)
    `BCCC_ASSERT_IMP(a_quo_bound, aclk, aresetn, dv_vld_reg[DIV_STAGES-1] && dv_side_reg[DIV_STAGES-1].hit && (dv_side_reg[DIV_STAGES-1].len != '0), (quo_x <= QUO_W'(dv_side_reg[DIV_STAGES-1].rml)) && (quo_y <= QUO_W'(dv_side_reg[DIV_STAGES-1].rml)))

endmodule

@@ verif/box_circle_collision_correction_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box/circle collision correction checker
// Watches both channels and the tolerance register. It predicts the push
// vector of every accepted pair, queues it, and compares each result word in
// order, field by field.
// ----------------------------------------------------------------------------
module box_circle_collision_correction_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bccc_pkg::SIZE_W-1:0]          cfg_wr_data,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_first_is_circle,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_first_center_x,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_first_center_y,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_first_size_x,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_first_size_y,
    input  logic                                 s_second_is_circle,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_second_center_x,
    input  logic signed [bccc_pkg::COORD_W-1:0]  s_second_center_y,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_second_size_x,
    input  logic [bccc_pkg::SIZE_W-1:0]          s_second_size_y,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [bccc_pkg::OUT_W-1:0]    m_push_x,
    input  logic signed [bccc_pkg::OUT_W-1:0]    m_push_y,
    output int                                   mismatch_count,
    output int                                   pushes_pending
);
    import bccc_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } push_t;

    push_t             expected_pushes[$];
    logic [SIZE_W-1:0] tol_shadow;

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned q);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > q) b = b >> 2;
        while (b != 0) begin
            if (q >= res + b) begin
                q = q - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // strict test: is (dx,dy) closer than r; len gets the floored distance
    function automatic bit in_reach(longint dx, longint dy, longint unsigned r,
                                    output longint unsigned len);
        longint unsigned ax, ay, rr, sx, sy;
        ax = magnitude(dx);
        ay = magnitude(dy);
        len = 0;
        if (ax >= r || ay >= r) return 0;
        rr = r * r;
        sx = ax * ax;
        sy = ay * ay;
        if (sx >= rr || sy >= rr - sx) return 0;
        len = root_floor(sx + sy);
        return 1;
    endfunction

    function automatic longint scaled_push(longint d, longint unsigned len,
                                           longint unsigned r);
        longint unsigned m;
        if (len == 0) return 0;
        m = (magnitude(d) * (r - len) + (len >> 1)) / len;
        return d > 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [OUT_W-1:0] halve_clip(longint v);
        longint h;
        if (v >= 0) h = (v + 1) / 2;
        else h = -((-v + 1) / 2);
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        return h[OUT_W-1:0];
    endfunction

    function automatic void add_corner(longint kx, longint ky, longint cx, longint cy,
                                       longint unsigned r, inout longint px,
                                       inout longint py);
        longint unsigned len;
        if (in_reach(kx - cx, ky - cy, r, len)) begin
            px += scaled_push(kx - cx, len, r);
            py += scaled_push(ky - cy, len, r);
        end
    endfunction

    function automatic push_t predict_push(logic mc, longint mx, longint my,
                                           longint msx, longint msy, logic rc,
                                           longint rx, longint ry, longint rsx,
                                           longint rsy, longint tol);
        longint px, py, cx, cy, x1, y1, x2, y2, rad;
        longint unsigned len, rsum;
        push_t p;
        px = 0;
        py = 0;
        if (!mc && !rc) begin
            if (!(ry - rsy > my + msy || ry + rsy < my - msy)) begin
                if (rx > mx && rx - rsx < mx + msx) px += (rx - rsx) - (mx + msx);
                if (rx < mx && rx + rsx > mx - msx) px += (rx + rsx) - (mx - msx);
            end
            if (!(rx - rsx > mx + msx || rx + rsx < mx - msx)) begin
                if (ry > my && ry - rsy < my + msy) py += (ry - rsy) - (my + msy);
                if (ry < my && ry + rsy > my - msy) py += (ry + rsy) - (my - msy);
            end
            if (longint'(magnitude(px)) > 2 * tol) px = 0;
            if (longint'(magnitude(py)) > 2 * tol) py = 0;
        end else if (mc && rc) begin
            rsum = msx + rsx;
            if (in_reach(rx - mx, ry - my, rsum, len)) begin
                px = scaled_push(rx - mx, len, rsum);
                py = scaled_push(ry - my, len, rsum);
            end
        end else begin
            if (mc) begin
                cx = mx; cy = my; rad = msx;
                x1 = rx - rsx; y1 = ry - rsy; x2 = rx + rsx; y2 = ry + rsy;
            end else begin
                cx = rx; cy = ry; rad = rsx;
                x1 = mx - msx; y1 = my - msy; x2 = mx + msx; y2 = my + msy;
            end
            if (cx > x1 && cx < x2) begin
                if (cy < y1 && cy + rad > y1) py += y1 - rad - cy;
                if (cy > y2 && cy - rad < y2) py += y2 + rad - cy;
            end
            if (cy > y1 && cy < y2) begin
                if (cx < x1 && cx + rad > x1) px += x1 - rad - cx;
                if (cx > x2 && cx - rad < x2) px += x2 + rad - cx;
            end
            if (cx <= x1 && cy <= y1) add_corner(x1, y1, cx, cy, rad, px, py);
            if (cx >= x2 && cy <= y1) add_corner(x2, y1, cx, cy, rad, px, py);
            if (cx <= x1 && cy >= y2) add_corner(x1, y2, cx, cy, rad, px, py);
            if (cx >= x2 && cy >= y2) add_corner(x2, y2, cx, cy, rad, px, py);
            if (!mc) begin
                px = -px;
                py = -py;
            end
        end
        p.x = halve_clip(px);
        p.y = halve_clip(py);
        return p;
    endfunction

    initial begin
        mismatch_count = 0;
        pushes_pending = 0;
        tol_shadow = TOL_RESET;
    end

    always @(posedge aclk) begin
        push_t got, want;
        if (!aresetn) begin
            tol_shadow = TOL_RESET;
        end else begin
            if (s_valid && s_ready) begin
                // centers doubled; sizes already are half sizes in doubled units
                expected_pushes.push_back(predict_push(
                    s_first_is_circle, 2 * longint'(s_first_center_x),
                    2 * longint'(s_first_center_y), longint'(s_first_size_x),
                    longint'(s_first_size_y), s_second_is_circle,
                    2 * longint'(s_second_center_x), 2 * longint'(s_second_center_y),
                    longint'(s_second_size_x), longint'(s_second_size_y),
                    longint'(tol_shadow)));
            end
            if (m_valid && m_ready) begin
                got.x = m_push_x;
                got.y = m_push_y;
                if (expected_pushes.size() == 0) begin
                    $display("%0t: unexpected word push_x=%0d push_y=%0d",
                             $time, got.x, got.y);
                    mismatch_count++;
                end else begin
                    want = expected_pushes.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t: push_x expected %0d actual %0d",
                                 $time, want.x, got.x);
                        mismatch_count++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t: push_y expected %0d actual %0d",
                                 $time, want.y, got.y);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) tol_shadow = cfg_wr_data;
        end
        pushes_pending = expected_pushes.size();
    end

endmodule

@@ verif/tb_box_circle_collision_correction.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box/circle collision correction testbench
// Drives directed and random shape pairs through several tolerance settings,
// with random stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_box_circle_collision_correction;
    import bccc_pkg::*;

    localparam int DRAIN_CYCLES = 90;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic                      fc, sc;
        logic signed [COORD_W-1:0] fx, fy, sx, sy;
        logic [SIZE_W-1:0]         fw, fh, sw, sh;
    } pair_t;

    logic                      aclk = 0;
    logic                      aresetn = 0;
    logic                      cfg_wr_en = 0;
    logic [SIZE_W-1:0]         cfg_wr_data = 0;
    logic                      s_valid = 0;
    logic                      s_ready;
    logic                      s_first_is_circle = 0, s_second_is_circle = 0;
    logic signed [COORD_W-1:0] s_first_center_x = 0, s_first_center_y = 0;
    logic signed [COORD_W-1:0] s_second_center_x = 0, s_second_center_y = 0;
    logic [SIZE_W-1:0]         s_first_size_x = 0, s_first_size_y = 0;
    logic [SIZE_W-1:0]         s_second_size_x = 0, s_second_size_y = 0;
    logic                      m_valid;
    logic                      m_ready = 0;
    logic signed [OUT_W-1:0]   m_push_x, m_push_y;
    int                        mismatch_count, pushes_pending;
    bit                        quiet = 0;
    bit                        hold_sink = 0;
    int                        idle_cycles = 0;

    always #6 aclk = ~aclk;

    box_circle_collision_correction dut (.*);

    box_circle_collision_correction_checker checker_i (.*);

    // sink side: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_sink = 0;
                m_ready <= 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 3) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("box_circle_collision_correction regression: fail");
            $finish;
        end
    end

    task automatic send_pair(pair_t p);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid            <= 1;
        s_first_is_circle  <= p.fc;
        s_first_center_x   <= p.fx;
        s_first_center_y   <= p.fy;
        s_first_size_x     <= p.fw;
        s_first_size_y     <= p.fh;
        s_second_is_circle <= p.sc;
        s_second_center_x  <= p.sx;
        s_second_center_y  <= p.sy;
        s_second_size_x    <= p.sw;
        s_second_size_y    <= p.sh;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drain the pipe, then write the tolerance while idle
    task automatic set_tolerance(logic [SIZE_W-1:0] value);
        s_valid <= 0;
        @(posedge aclk);
        while (pushes_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [SIZE_W-1:0] any_size();
        logic [SIZE_W-1:0] v;
        v = $urandom;
        return v >> $urandom_range(0, SIZE_W - 1);
    endfunction

    function automatic logic signed [COORD_W-1:0] near_offset();
        logic signed [COORD_W-1:0] v;
        v = $urandom >> $urandom_range(2, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // mostly overlapping neighbors at a shared scale, some pure noise
    function automatic pair_t random_pair();
        pair_t p;
        int sh;
        p.fc = $urandom_range(0, 1);
        p.sc = $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0) begin
            p.fx = $urandom; p.fy = $urandom; p.sx = $urandom; p.sy = $urandom;
            p.fw = $urandom; p.fh = $urandom; p.sw = $urandom; p.sh = $urandom;
        end else begin
            sh = $urandom_range(0, 20);
            p.fx = $urandom;
            p.fy = $urandom;
            p.sx = p.fx + (near_offset() >>> sh);
            p.sy = p.fy + (near_offset() >>> sh);
            p.fw = ($urandom >> 2) >> sh;
            p.fh = ($urandom >> 2) >> sh;
            p.sw = ($urandom >> 2) >> sh;
            p.sh = ($urandom >> 2) >> sh;
            if ($urandom_range(0, 7) == 0) p.fw = any_size();
            if ($urandom_range(0, 7) == 0) p.sw = 0;
        end
        return p;
    endfunction

    function automatic pair_t make_pair(logic fc, int fx, int fy, int fw, int fh,
                                        logic sc, int sx, int sy, int sw, int sh);
        pair_t p;
        p.fc = fc; p.fx = fx; p.fy = fy; p.fw = fw; p.fh = fh;
        p.sc = sc; p.sx = sx; p.sy = sy; p.sw = sw; p.sh = sh;
        return p;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_pair(random_pair());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed corners at the reset tolerance
        send_pair(make_pair(0, 0, 0, 65536, 65536, 0, 70000, 0, 65536, 65536));
        send_pair(make_pair(0, 0, 0, 65536, 65536, 0, 0, -3000, 65536, 65536));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(1, 0, 0, 65536, 0, 1, 0, 0, 65536, 0));
        send_pair(make_pair(1, 0, 0, 65536, 0, 1, 65536, 0, 65536, 0));
        send_pair(make_pair(1, 0, 0, 65536, 0, 1, 30000, -20000, 65536, 0));
        send_pair(make_pair(1, 0, 0, 65536, 0, 0, 50000, 0, 65536, 65536));
        send_pair(make_pair(0, 50000, 0, 65536, 65536, 1, 0, 0, 65536, 0));
        send_pair(make_pair(1, 0, 0, 65536, 0, 0, 100000, 100000, 65536, 65536));
        send_pair(make_pair(0, 0, 0, 0, 0, 1, 100, 100, 65536, 0));
        send_pair(make_pair(1, 0, 0, 65536, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            1, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
        send_pair(make_pair(0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                            0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_pair(make_pair(1, 32'h80000000, 0, 32'h7fffffff, 0,
                            0, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff));
        send_pair(make_pair(0, -1, -1, 32'h7fffffff, 1, 1, 1, 1, 1, 32'h7fffffff));
        random_phase(160);

        set_tolerance(0);
        random_phase(60);
        hold_sink = 1;
        random_phase(120);

        set_tolerance(31'h7fffffff);
        random_phase(180);

        set_tolerance($urandom_range(0, 200000));
        random_phase(180);

        set_tolerance(TOL_RESET);
        quiet = 1;
        random_phase(180);

        s_valid <= 0;
        @(posedge aclk);
        while (pushes_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pushes_pending == 0)
            $display("box_circle_collision_correction regression: pass");
        else
            $display("box_circle_collision_correction regression: fail");
        $finish;
    end

endmodule
